/* hdl/multichannel_exponential_smoother_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel exponential smoother
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_EXPONENTIAL_SMOOTHER_ASSERT_SVH
`define MULTICHANNEL_EXPONENTIAL_SMOOTHER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: when ante holds, cons holds.
`define ASSERT_IMPLY(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("smoother assertion failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("smoother assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk_i, rst_n_i, ante, cons)
`define ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons)

`endif

`endif

/* hdl/mes_pkg.sv */
// ----------------------------------------------------------------------------
// mes_pkg
// Shared types and codes of the multichannel exponential smoother.
// ----------------------------------------------------------------------------
package mes_pkg;

	// Field widths fixed by the stream format.
	localparam int unsigned SAMPLE_W    = 48;
	localparam int unsigned CHAN_W      = 8;
	localparam int unsigned FACTOR_W    = 17;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned IN_TDATA_W  = 56;
	localparam int unsigned IN_TUSER_W  = 4;
	localparam int unsigned OUT_TDATA_W = 56;

	// Weight of 1.0 in Q1.16.
	localparam logic [FACTOR_W-1:0] ONE_Q16 = 17'd65536;

	// Request codes.
	localparam logic [1:0] REQ_STORE_EMIT = 2'd0;
	localparam logic [1:0] REQ_STORE_ONLY = 2'd1;
	localparam logic [1:0] REQ_REPLAY     = 2'd2;

	// Sample kind codes; other codes are non-numeric.
	localparam logic [1:0] KIND_INT  = 2'd0;
	localparam logic [1:0] KIND_FRAC = 2'd1;

	// Output style codes.
	localparam logic [1:0] STYLE_FOLLOW = 2'd0;
	localparam logic [1:0] STYLE_INT    = 2'd1;
	localparam logic [1:0] STYLE_FRAC   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_ON = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STYLE     = 2'd2;

	// Output queue geometry.
	localparam int unsigned OFIFO_DEPTH = 4;
	localparam int unsigned OFIFO_AW    = 2;
	localparam int unsigned OFIFO_CW    = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Configuration as seen by the arithmetic.
	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		logic                smooth_on;
		logic [1:0]          style;
	} cfg_t;

	// One channel's state entry.
	typedef struct packed {
		logic    sm_int;
		sample_t smoothed;
		logic    in_frac;
		sample_t stored_in;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		sm_int:    1'b1,
		smoothed:  '0,
		in_frac:   1'b0,
		stored_in: '0
	};

	// One result item.
	typedef struct packed {
		logic [CHAN_W-1:0] ch;
		sample_t           smoothed;
		logic              is_int;
		logic              last;
	} result_t;

endpackage

/* hdl/mes_blend.sv */
// ----------------------------------------------------------------------------
// mes_blend
// One-pole blend of a new sample into the old smoothed value, with rounding
// half away from zero to a fractional or an integer result.
// ----------------------------------------------------------------------------
module mes_blend #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  mes_pkg::cfg_t    cfg,
	input  mes_pkg::sample_t cur_in,
	input  logic             cur_frac,
	input  mes_pkg::sample_t old_val,
	input  logic             old_int,
	output mes_pkg::sample_t new_val,
	output logic             new_int
);

	localparam int unsigned SH = 16 + FRAC_BITS;
	localparam logic [64:0] HALF_F  = 65'd1 << 15;
	localparam logic [64:0] HALF_I  = 65'd1 << (SH - 1);
	localparam logic [64:0] MAX_INT = (((65'd1 << 47) - 65'd1) >> FRAC_BITS) << FRAC_BITS;

	logic [mes_pkg::FACTOR_W-1:0] a_eff;
	logic signed [48:0]           diff;
	logic signed [66:0]           prod;
	logic signed [66:0]           p;
	logic signed [66:0]           p_neg;
	logic                         neg;
	logic [64:0]                  mag;
	logic [64:0]                  sum_f;
	logic [64:0]                  q_f;
	logic [64:0]                  sum_i;
	logic [64:0]                  v_i;
	logic [47:0]                  t_f;
	logic [47:0]                  t_i;
	mes_pkg::sample_t             res_f;
	mes_pkg::sample_t             res_i;

	// Effective weight: clamp above one, and one when smoothing is off.
	always_comb begin
		if (!cfg.smooth_on || (cfg.factor > mes_pkg::ONE_Q16)) begin
			a_eff = mes_pkg::ONE_Q16;
		end else begin
			a_eff = cfg.factor;
		end
	end

	// p = old*1.0 + a*(in - old), exact with 16 + FRAC_BITS fraction bits.
	always_comb begin
		diff  = $signed({cur_in[47], cur_in}) - $signed({old_val[47], old_val});
		prod  = $signed({1'b0, a_eff}) * diff;
		p     = prod + $signed({{3{old_val[47]}}, old_val, 16'b0});
		p_neg = -p;
		neg   = p[66];
		mag   = neg ? p_neg[64:0] : p[64:0];
	end

	// Fractional result: round off the weight's 16 fraction bits.
	always_comb begin
		sum_f = mag + HALF_F;
		q_f   = sum_f >> 16;
		t_f   = q_f[47:0];
		res_f = neg ? (48'd0 - t_f) : t_f;
	end

	// Integer result: round to a whole number, saturate on the positive side.
	always_comb begin
		sum_i = mag + HALF_I;
		v_i   = (sum_i >> SH) << FRAC_BITS;
		if (!neg && (v_i > MAX_INT)) begin
			v_i = MAX_INT;
		end
		t_i   = v_i[47:0];
		res_i = neg ? (48'd0 - t_i) : t_i;
	end

	// Pick the result kind; an undefined style leaves the value alone.
	always_comb begin
		unique case (cfg.style)
			mes_pkg::STYLE_FOLLOW: begin
				new_int = !cur_frac;
				new_val = cur_frac ? res_f : res_i;
			end
			mes_pkg::STYLE_INT: begin
				new_int = 1'b1;
				new_val = res_i;
			end
			mes_pkg::STYLE_FRAC: begin
				new_int = 1'b0;
				new_val = res_f;
			end
			default: begin
				new_int = old_int;
				new_val = old_val;
			end
		endcase
	end

endmodule

/* hdl/mes_ofifo.sv */
// ----------------------------------------------------------------------------
// mes_ofifo
// Small output queue that parts the result stream from the pipeline.
// ----------------------------------------------------------------------------
module mes_ofifo (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  mes_pkg::result_t                     din,
	input  logic                                 pop,
	output mes_pkg::result_t                     dout,
	output logic [mes_pkg::OFIFO_CW-1:0]         count
);

	mes_pkg::result_t                 slot_q [mes_pkg::OFIFO_DEPTH];
	logic [mes_pkg::OFIFO_AW-1:0]     wr_ptr_q;
	logic [mes_pkg::OFIFO_AW-1:0]     rd_ptr_q;
	logic [mes_pkg::OFIFO_CW-1:0]     cnt_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	assign dout  = slot_q[rd_ptr_q];
	assign count = cnt_q;

endmodule

/* hdl/multichannel_exponential_smoother.sv */
// ----------------------------------------------------------------------------
// multichannel_exponential_smoother
// Per-channel one-pole smoother: state memory with read-modify-write,
// forwarding of the last write, and a small output queue.
// ----------------------------------------------------------------------------
//
//  Channel  | Group          | Contents
//  ---------+----------------+-----------------------------------------------
//  config   | cfg_*          | register index and write data, always ready
//  input    | s_axis_*       | request, channel, sample, kind, end of list
//  output   | m_axis_*       | channel, smoothed value, integer flag, end mark
//
//  One item per cycle is accepted while input ready is high. A result is
//  registered in stage one and then queued before it is presented on the
//  output. The rate is held by the loop through the state memory
//  forwarding path and the blend multiplier. Reset clears the entry valid
//  bits at once, so no clearing pass is needed. Input ready drops while the
//  queued results plus the one about to be queued reach three.
//
`include "multichannel_exponential_smoother_assert.svh"

module multichannel_exponential_smoother #(
	parameter int unsigned CHANNELS  = 256,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mes_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mes_pkg::FACTOR_W-1:0]         cfg_data,
	// Input stream.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [mes_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // channel, sample
	input  logic [mes_pkg::IN_TUSER_W-1:0]       s_axis_tuser,  // req_type, sample_kind
	input  logic                                 s_axis_tlast,
	// Output stream.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [mes_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // out_channel, smoothed
	output logic [0:0]                           m_axis_tuser,  // is_integer
	output logic                                 m_axis_tlast
);

	localparam int unsigned DEPTH    = (CHANNELS > 256) ? 256 : CHANNELS;
	localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [8:0]  CH_LIMIT = 9'(DEPTH);

	mes_pkg::cfg_t                    cfg_q;

	logic [1:0]                       in_req;
	logic [1:0]                       in_kind;
	logic [mes_pkg::CHAN_W-1:0]       in_ch;
	mes_pkg::sample_t                 in_sample;
	logic                             in_fire;
	logic                             req_ok;
	logic                             in_act;
	logic                             in_emit;
	logic                             kind_num;
	mes_pkg::sample_t                 in_store;

	logic                             v_s1;
	logic                             emit_s1;
	logic [1:0]                       req_s1;
	logic [AW-1:0]                    addr_s1;
	logic [mes_pkg::CHAN_W-1:0]       ch_s1;
	mes_pkg::sample_t                 in_s1;
	logic                             frac_s1;
	logic                             last_s1;
	mes_pkg::entry_t                  rd_s1;
	logic                             rvld_s1;

	mes_pkg::entry_t                  mem [DEPTH];
	logic [DEPTH-1:0]                 vld_q;

	logic                             wbv_q;
	logic [AW-1:0]                    wb_addr_q;
	mes_pkg::entry_t                  wb_q;

	logic                             fwd_hit;
	mes_pkg::entry_t                  old_ent;
	mes_pkg::sample_t                 cur_in;
	logic                             cur_frac;
	mes_pkg::sample_t                 bl_val;
	logic                             bl_int;
	mes_pkg::entry_t                  new_ent;
	logic                             wr_en;

	mes_pkg::result_t                 res_push;
	mes_pkg::result_t                 res_head;
	logic                             pop;
	logic [mes_pkg::OFIFO_CW-1:0]     ocnt;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.factor    <= 17'd6554;
			cfg_q.smooth_on <= 1'b1;
			cfg_q.style     <= mes_pkg::STYLE_FOLLOW;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mes_pkg::CFG_FACTOR:    cfg_q.factor    <= cfg_data;
				mes_pkg::CFG_SMOOTH_ON: cfg_q.smooth_on <= cfg_data[0];
				mes_pkg::CFG_STYLE:     cfg_q.style     <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// Input field unpacking and request decode.
	assign in_req    = s_axis_tuser[1:0];
	assign in_kind   = s_axis_tuser[3:2];
	assign in_ch     = s_axis_tdata[7:0];
	assign in_sample = s_axis_tdata[55:8];
	assign in_fire   = s_axis_tvalid && s_axis_tready;

	always_comb begin
		unique case (in_req) inside
			mes_pkg::REQ_STORE_EMIT,
			mes_pkg::REQ_STORE_ONLY,
			mes_pkg::REQ_REPLAY: req_ok = 1'b1;
			default:             req_ok = 1'b0;
		endcase
	end

	assign in_act   = in_fire && req_ok && ({1'b0, in_ch} < CH_LIMIT);
	assign in_emit  = in_act && (in_req != mes_pkg::REQ_STORE_ONLY);
	assign kind_num = (in_kind == mes_pkg::KIND_INT) || (in_kind == mes_pkg::KIND_FRAC);
	assign in_store = kind_num ? in_sample : '0;

	// Ready from registered state only: leave room for every result in flight.
	assign s_axis_tready = (ocnt + mes_pkg::OFIFO_CW'(emit_s1))
		< mes_pkg::OFIFO_CW'(mes_pkg::OFIFO_DEPTH - 1);

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			v_s1    <= in_act;
			emit_s1 <= in_emit;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		req_s1  <= in_req;
		addr_s1 <= in_ch[AW-1:0];
		ch_s1   <= in_ch;
		in_s1   <= in_store;
		frac_s1 <= (in_kind == mes_pkg::KIND_FRAC);
		last_s1 <= s_axis_tlast;
	end

	// State memory: one write port from stage one, registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= new_ent;
		end
		rd_s1 <= mem[in_ch[AW-1:0]];
	end

	// Entry valid bits: an entry never written reads as the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= vld_q[in_ch[AW-1:0]];
			if (wr_en) begin
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	// Last write, kept for the item right behind it on the same channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbv_q <= 1'b0;
		end else begin
			wbv_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		wb_addr_q <= addr_s1;
		wb_q      <= new_ent;
	end

	// Old entry with forwarding.
	assign fwd_hit = v_s1 && wbv_q && (wb_addr_q == addr_s1);

	always_comb begin
		if (fwd_hit) begin
			old_ent = wb_q;
		end else if (rvld_s1) begin
			old_ent = rd_s1;
		end else begin
			old_ent = mes_pkg::ENTRY_RESET;
		end
	end

	// Replay works from the stored input; other requests store the new one.
	assign cur_in   = (req_s1 == mes_pkg::REQ_REPLAY) ? old_ent.stored_in : in_s1;
	assign cur_frac = (req_s1 == mes_pkg::REQ_REPLAY) ? old_ent.in_frac : frac_s1;

	mes_blend #(
		.FRAC_BITS (FRAC_BITS)
	) u_blend (
		.cfg      (cfg_q),
		.cur_in   (cur_in),
		.cur_frac (cur_frac),
		.old_val  (old_ent.smoothed),
		.old_int  (old_ent.sm_int),
		.new_val  (bl_val),
		.new_int  (bl_int)
	);

	// New entry; a store-only request keeps the smoothed value.
	always_comb begin
		new_ent.stored_in = cur_in;
		new_ent.in_frac   = cur_frac;
		if (req_s1 == mes_pkg::REQ_STORE_ONLY) begin
			new_ent.smoothed = old_ent.smoothed;
			new_ent.sm_int   = old_ent.sm_int;
		end else begin
			new_ent.smoothed = bl_val;
			new_ent.sm_int   = bl_int;
		end
	end

	assign wr_en = v_s1;

	// Result item into the output queue.
	assign res_push.ch       = ch_s1;
	assign res_push.smoothed = new_ent.smoothed;
	assign res_push.is_int   = new_ent.sm_int;
	assign res_push.last     = last_s1;

	assign pop = m_axis_tvalid && m_axis_tready;

	mes_ofifo u_ofifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (emit_s1),
		.din    (res_push),
		.pop    (pop),
		.dout   (res_head),
		.count  (ocnt)
	);

	// Output stream packing.
	assign m_axis_tvalid   = (ocnt != '0);
	assign m_axis_tdata    = {res_head.smoothed, res_head.ch};
	assign m_axis_tuser[0] = res_head.is_int;
	assign m_axis_tlast    = res_head.last;

	// Checks.
	`ASSERT_IMPLY(a_fifo_room, clk, arst_n, emit_s1, (ocnt < mes_pkg::OFIFO_CW'(mes_pkg::OFIFO_DEPTH)) || pop)
	`ASSERT_NEXT(a_result_queued, clk, arst_n, emit_s1, ocnt != '0)
	`ASSERT_IMPLY(a_fwd_source, clk, arst_n, fwd_hit, $past(v_s1) && ($past(addr_s1) == addr_s1))

endmodule
